/* rtl/cbb_pkg.sv */
// Package for the cascaded biquad band-pass filter.
// Holds shared constants, register indexes, sequencer states and the MAC control struct.
// No dependencies.
package cbb_pkg;

    localparam int MAX_STAGES_DEF  = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS       = 32;
    localparam int COEF_FRAC       = 30;
    localparam int ACC_BITS        = 64;
    localparam int ACTIVE_BITS     = 4;
    localparam int CFG_IDX_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] REG_FF0    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF1    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF2    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB1    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB2    = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_ACTIVE = 3'd5;

    localparam logic [2:0] PH_X    = 3'd0;
    localparam logic [2:0] PH_X1   = 3'd1;
    localparam logic [2:0] PH_X2   = 3'd2;
    localparam logic [2:0] PH_Y1   = 3'd3;
    localparam logic [2:0] PH_Y2   = 3'd4;
    localparam logic [2:0] PH_RND  = 3'd5;
    localparam logic [2:0] PH_LAST = 3'd6;
    localparam logic [2:0] PH_WB   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic round;
        logic sub;
        logic acc_en;
        logic acc_clear;
    } t_mac_ctrl;

endpackage

/* rtl/cbb_mac.sv */
// Shared multiply-accumulate unit: registered product, then 64-bit saturating add/subtract.
// Depends on cbb_pkg.
module cbb_mac #(
    parameter int SAMPLE_BITS = cbb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                 i_clk,
    input  cbb_pkg::t_mac_ctrl                   i_ctrl,
    input  logic signed [SAMPLE_BITS-1:0]        i_opa,
    input  logic signed [cbb_pkg::COEF_BITS-1:0] i_coef,
    output logic signed [cbb_pkg::ACC_BITS-1:0]  o_acc
);
    localparam int PW = SAMPLE_BITS + cbb_pkg::COEF_BITS;
    localparam int AW = cbb_pkg::ACC_BITS;
    localparam logic signed [PW-1:0] ROUND_K = PW'(64'd1 << (cbb_pkg::COEF_FRAC - 1));
    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    logic signed [PW-1:0] r_prod;
    logic                 r_sub;
    logic signed [AW-1:0] r_acc;
    logic signed [PW-1:0] n_prod;
    logic signed [AW:0]   w_base;
    logic signed [AW:0]   w_term;
    logic signed [AW:0]   w_sum;
    logic signed [AW-1:0] n_acc;

    assign n_prod = i_opa * i_coef;

    always_comb begin
        w_base = i_ctrl.acc_clear ? '0 : {r_acc[AW-1], r_acc};
        w_term = (AW+1)'(r_prod);
        if (r_sub) begin
            w_term = -w_term;
        end
        w_sum = w_base + w_term;
        if (w_sum[AW] != w_sum[AW-1]) begin
            n_acc = w_sum[AW] ? ACC_MIN : ACC_MAX;
        end else begin
            n_acc = w_sum[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_ctrl.round ? ROUND_K : n_prod;
            r_sub  <= i_ctrl.sub;
        end
        if (i_ctrl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/cascaded_biquad_bandpass.sv */
// Cascaded biquad band-pass filter, direct form 1, one shared MAC under a phase sequencer.
// A sample runs through the n active sections in turn (none: it passes unchanged); each
// section takes five multiply-accumulates, a rounding add and a write-back on the one MAC.
// A new request is taken only while the sequencer idles, once the last sample is done.
// Reset (synchronous, active low): history cleared, coefficients 0, active sections 1.
module cascaded_biquad_bandpass #(
    parameter int MAX_STAGES  = cbb_pkg::MAX_STAGES_DEF,
    parameter int SAMPLE_BITS = cbb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_sample_valid,
    output logic                                    o_sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]           i_sample_in,
    output logic                                    o_result_valid,
    input  logic                                    i_result_ready,
    output logic signed [SAMPLE_BITS-1:0]           o_sample_out,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [cbb_pkg::CFG_IDX_BITS-1:0]        i_cfg_index,
    input  logic [cbb_pkg::COEF_BITS-1:0]           i_cfg_data
);
    localparam int CW = $clog2(MAX_STAGES + 1);
    localparam int IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int SB = SAMPLE_BITS;
    localparam int YW = cbb_pkg::ACC_BITS - cbb_pkg::COEF_FRAC;
    localparam logic signed [YW-1:0] Y_MAX = YW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [YW-1:0] Y_MIN = YW'(-(64'sd1 <<< (SB - 1)));

    logic signed [cbb_pkg::COEF_BITS-1:0] r_ff0, r_ff1, r_ff2, r_fb1, r_fb2;
    logic [cbb_pkg::ACTIVE_BITS-1:0]      r_active;

    logic signed [SB-1:0] r_in1  [MAX_STAGES];
    logic signed [SB-1:0] r_in2  [MAX_STAGES];
    logic signed [SB-1:0] r_out1 [MAX_STAGES];
    logic signed [SB-1:0] r_out2 [MAX_STAGES];

    cbb_pkg::t_state r_state, n_state;
    logic [2:0]      r_phase;
    logic [CW-1:0]   r_stage;
    logic signed [SB-1:0] r_x;
    logic signed [SB-1:0] r_out;
    logic                 r_out_valid;

    logic [CW-1:0]        w_n_eff;
    logic                 w_last;
    logic                 w_out_free;
    logic [IW-1:0]        w_idx;
    logic signed [SB-1:0] w_opa;
    logic signed [cbb_pkg::COEF_BITS-1:0] w_coef;
    cbb_pkg::t_mac_ctrl   w_ctrl;
    logic signed [cbb_pkg::ACC_BITS-1:0]  w_acc;
    logic signed [YW-1:0] w_shift;
    logic signed [SB-1:0] w_y;

    assign w_n_eff = ({1'b0, r_active} > 5'(MAX_STAGES)) ? CW'(MAX_STAGES) : CW'(r_active);
    assign w_last     = (CW'(r_stage + 1'b1) == w_n_eff);
    assign w_out_free = !r_out_valid || i_result_ready;
    assign w_idx      = r_stage[IW-1:0];
    assign o_cfg_ready = 1'b1;

    // Operand and coefficient select for the current phase
    always_comb begin
        case (r_phase)
            cbb_pkg::PH_X: begin
                w_opa  = r_x;
                w_coef = r_ff0;
            end
            cbb_pkg::PH_X1: begin
                w_opa  = r_in1[w_idx];
                w_coef = r_ff1;
            end
            cbb_pkg::PH_X2: begin
                w_opa  = r_in2[w_idx];
                w_coef = r_ff2;
            end
            cbb_pkg::PH_Y1: begin
                w_opa  = r_out1[w_idx];
                w_coef = r_fb1;
            end
            cbb_pkg::PH_Y2: begin
                w_opa  = r_out2[w_idx];
                w_coef = r_fb2;
            end
            default: begin
                w_opa  = r_x;
                w_coef = r_ff0;
            end
        endcase
    end

    cbb_mac #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_mac (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .i_opa  (w_opa),
        .i_coef (w_coef),
        .o_acc  (w_acc)
    );

    // Shift the rounded accumulator down by the coefficient fraction, then clamp to sample range
    always_comb begin
        w_shift = w_acc[cbb_pkg::ACC_BITS-1:cbb_pkg::COEF_FRAC];
        if (w_shift > Y_MAX) begin
            w_y = Y_MAX[SB-1:0];
        end else if (w_shift < Y_MIN) begin
            w_y = Y_MIN[SB-1:0];
        end else begin
            w_y = w_shift[SB-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cbb_pkg::ST_IDLE: begin
                if (i_sample_valid) begin
                    n_state = (w_n_eff == '0) ? cbb_pkg::ST_DONE : cbb_pkg::ST_CALC;
                end
            end
            cbb_pkg::ST_CALC: begin
                if (r_phase == cbb_pkg::PH_WB && w_last) begin
                    n_state = cbb_pkg::ST_DONE;
                end
            end
            cbb_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = cbb_pkg::ST_IDLE;
                end
            end
            default: n_state = cbb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_sample_ready   = (r_state == cbb_pkg::ST_IDLE);
        w_ctrl.mul_en    = (r_state == cbb_pkg::ST_CALC) && (r_phase <= cbb_pkg::PH_RND);
        w_ctrl.round     = (r_phase == cbb_pkg::PH_RND);
        w_ctrl.sub       = (r_phase == cbb_pkg::PH_Y1) || (r_phase == cbb_pkg::PH_Y2);
        w_ctrl.acc_en    = (r_state == cbb_pkg::ST_CALC) && (r_phase >= cbb_pkg::PH_X1)
                           && (r_phase <= cbb_pkg::PH_LAST);
        w_ctrl.acc_clear = (r_phase == cbb_pkg::PH_X1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cbb_pkg::ST_IDLE;
            r_phase     <= '0;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == cbb_pkg::ST_IDLE) begin
                r_phase <= '0;
                r_stage <= '0;
            end else if (r_state == cbb_pkg::ST_CALC) begin
                r_phase <= r_phase + 3'd1;
                if (r_phase == cbb_pkg::PH_WB) begin
                    r_stage <= r_stage + 1'b1;
                end
            end
            if (r_state == cbb_pkg::ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == cbb_pkg::ST_IDLE && i_sample_valid) begin
            r_x <= i_sample_in;
        end else if (r_state == cbb_pkg::ST_CALC && r_phase == cbb_pkg::PH_WB) begin
            r_x <= w_y;
        end
        if (r_state == cbb_pkg::ST_DONE && w_out_free) begin
            r_out <= r_x;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_sample_out   = r_out;

    // Shift section history at write-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_STAGES; i++) begin
                r_in1[i]  <= '0;
                r_in2[i]  <= '0;
                r_out1[i] <= '0;
                r_out2[i] <= '0;
            end
        end else if (r_state == cbb_pkg::ST_CALC && r_phase == cbb_pkg::PH_WB) begin
            r_in2[w_idx]  <= r_in1[w_idx];
            r_in1[w_idx]  <= r_x;
            r_out2[w_idx] <= r_out1[w_idx];
            r_out1[w_idx] <= w_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0    <= '0;
            r_ff1    <= '0;
            r_ff2    <= '0;
            r_fb1    <= '0;
            r_fb2    <= '0;
            r_active <= cbb_pkg::ACTIVE_BITS'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cbb_pkg::REG_FF0:    r_ff0    <= i_cfg_data;
                cbb_pkg::REG_FF1:    r_ff1    <= i_cfg_data;
                cbb_pkg::REG_FF2:    r_ff2    <= i_cfg_data;
                cbb_pkg::REG_FB1:    r_fb1    <= i_cfg_data;
                cbb_pkg::REG_FB2:    r_fb2    <= i_cfg_data;
                cbb_pkg::REG_ACTIVE: r_active <= i_cfg_data[cbb_pkg::ACTIVE_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule
